// ----- rtl/drs_pkg.sv -----
// shared types and constants of the decimal lsd radix sorter
// used by drs_ctrl, drs_datapath and decimal_lsd_radix_sort
`default_nettype none
package drs_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned VAL_W         = 31;
  localparam int unsigned RADIX         = 10;
  localparam int unsigned DIG_W         = 4;
  localparam int unsigned WORD_W        = 2 * VAL_W;
  localparam int unsigned PROD_W        = 63;
  localparam int unsigned DIV10_SHIFT   = 35;
  localparam logic [31:0] DIV10_MUL     = 32'hCCCC_CCCD;
  localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(RADIX - 1);

  typedef enum logic [1:0] {
    OP_HIST,
    OP_PLACE,
    OP_MAXDIV
  } op_e;

  typedef struct packed {
    logic             load;
    logic             clr_set;
    logic             clr_counts;
    logic             issue;
    op_e              op;
    logic             prefix;
    logic [DIG_W-1:0] digit_sel;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic max_zero;
    logic pipe_busy;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/drs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module drs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire                                   clk_i,
  input  wire                                   we_i,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                       wdata_i,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/drs_datapath.sv -----
// datapath: item memories, divide-by-ten pipeline, digit histogram, output register
// depends on drs_pkg and drs_ram
`default_nettype none
module drs_datapath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  drs_pkg::cmd_t        cmd_i,
  input  wire [(MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1)-1:0] idx_i,
  input  wire [drs_pkg::VAL_W-1:0] in_value_i,
  output drs_pkg::sts_t        sts_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0] count_o,
  output logic [drs_pkg::VAL_W-1:0] out_value_o,
  output logic                 out_last_o,
  output logic                 out_drop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i
);
  import drs_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]     count_q;
  logic [VAL_W-1:0]  max_q;
  logic              ovf_q, sel_q;
  logic [CW-1:0]     counts_q [RADIX];
  logic [CW-1:0]     acc_q;
  logic              v1_q, v2_q;
  op_e               op1_q, op2_q;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  val2_q, q2_q;
  logic [VAL_W-1:0]  out_value_q;
  logic              out_last_q, out_drop_q, out_valid_q;

  logic [WORD_W-1:0] rdata_a, rdata_b, rd_word, wdata_a, wdata_b, place_word;
  logic [AW-1:0]     waddr_a, waddr_b;
  logic              we_a, we_b, full, place_we;
  logic [VAL_W-1:0]  opnd, qq, rem;
  logic [DIG_W-1:0]  digit, cidx;
  logic [CW-1:0]     cnt_rd, cnt_sum, pos;

  assign full    = (count_q == CW'(MAX_ITEMS));
  assign rd_word = sel_q ? rdata_b : rdata_a;
  assign opnd    = (op1_q == OP_MAXDIV) ? max_q : rd_word[WORD_W-1:VAL_W];

  assign qq      = VAL_W'(prod_q[PROD_W-1:DIV10_SHIFT]);
  assign rem     = q2_q - ((qq << 3) + (qq << 1));
  assign digit   = rem[DIG_W-1:0];
  assign cidx    = cmd_i.prefix ? cmd_i.digit_sel : digit;
  assign cnt_rd  = counts_q[cidx];
  assign cnt_sum = acc_q + cnt_rd;
  assign pos     = cnt_rd - CW'(1);

  assign place_we   = v2_q && (op2_q == OP_PLACE);
  assign place_word = {qq, val2_q};

  always_comb begin
    we_a    = 1'b0;
    waddr_a = pos[AW-1:0];
    wdata_a = place_word;
    we_b    = place_we && !sel_q;
    waddr_b = pos[AW-1:0];
    wdata_b = place_word;
    if (cmd_i.load) begin
      we_a    = !full;
      waddr_a = count_q[AW-1:0];
      wdata_a = {in_value_i, in_value_i};
    end else if (place_we && sel_q) begin
      we_a = 1'b1;
    end
  end

  drs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (wdata_a),
    .raddr_i (idx_i),
    .rdata_o (rdata_a)
  );

  drs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (wdata_b),
    .raddr_i (idx_i),
    .rdata_o (rdata_b)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(opnd) * PROD_W'(DIV10_MUL);
    val2_q <= rd_word[VAL_W-1:0];
    q2_q   <= opnd;
    if (cmd_i.out_load) begin
      out_value_q <= rd_word[VAL_W-1:0];
      out_last_q  <= cmd_i.out_last;
      out_drop_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      max_q       <= '0;
      ovf_q       <= 1'b0;
      sel_q       <= 1'b0;
      acc_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      op1_q       <= OP_HIST;
      op2_q       <= OP_HIST;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RADIX; i++) counts_q[i] <= '0;
    end else begin
      v1_q  <= cmd_i.issue;
      op1_q <= cmd_i.op;
      v2_q  <= v1_q;
      op2_q <= op1_q;

      if (cmd_i.clr_set) begin
        count_q <= '0;
        max_q   <= '0;
        ovf_q   <= 1'b0;
        sel_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
          if (in_value_i > max_q) max_q <= in_value_i;
        end
      end else if (v2_q && (op2_q == OP_MAXDIV)) begin
        max_q <= qq;
        sel_q <= !sel_q;
      end

      if (cmd_i.clr_counts) begin
        acc_q <= '0;
        for (int i = 0; i < RADIX; i++) counts_q[i] <= '0;
      end else if (cmd_i.prefix) begin
        acc_q          <= cnt_sum;
        counts_q[cidx] <= cnt_sum;
      end else if (v2_q && (op2_q == OP_HIST)) begin
        counts_q[cidx] <= cnt_rd + CW'(1);
      end else if (place_we) begin
        counts_q[cidx] <= pos;
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.max_zero  = (max_q == '0);
  assign sts_o.pipe_busy = v1_q || v2_q;
  assign sts_o.out_busy  = out_valid_q;
  assign count_o         = count_q;
  assign out_value_o     = out_value_q;
  assign out_last_o      = out_last_q;
  assign out_drop_o      = out_drop_q;
  assign out_valid_o     = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/drs_ctrl.sv -----
// controller: sequences loading, digit passes and output of the sorter
// depends on drs_pkg
`default_nettype none
module drs_ctrl #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_last_i,
  output logic                 in_ready_o,
  input  drs_pkg::sts_t        sts_i,
  input  wire [$clog2(MAX_ITEMS+1)-1:0] count_i,
  output drs_pkg::cmd_t        cmd_o,
  output logic [(MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1)-1:0] idx_o
);
  import drs_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_CHECK, S_HIST, S_HIST_WAIT, S_PREFIX, S_PLACE, S_PLACE_WAIT,
    S_DIV, S_DIV_WAIT, S_OUT_RD, S_OUT_LOAD, S_OUT_HOLD
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    i_q;
  logic [DIG_W-1:0] k_q;
  logic [CW-1:0]    last_idx;
  logic             at_last;

  assign last_idx   = count_i - CW'(1);
  assign at_last    = (CW'(i_q) == last_idx);
  assign in_ready_o = (state_q == S_LOAD);
  assign idx_o      = i_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = OP_HIST;
    cmd_o.digit_sel  = k_q;
    cmd_o.out_last   = at_last;
    unique case (state_q)
      S_LOAD:     cmd_o.load = in_valid_i;
      S_CHECK:    cmd_o.clr_counts = !sts_i.max_zero;
      S_HIST:     cmd_o.issue = 1'b1;
      S_PREFIX:   cmd_o.prefix = 1'b1;
      S_PLACE: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_PLACE;
      end
      S_DIV: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_MAXDIV;
      end
      S_OUT_LOAD: cmd_o.out_load = 1'b1;
      S_OUT_HOLD: cmd_o.clr_set = !sts_i.out_busy && at_last;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (in_valid_i && in_last_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          i_q     <= '0;
          state_q <= sts_i.max_zero ? S_OUT_RD : S_HIST;
        end
        S_HIST: begin
          if (at_last) state_q <= S_HIST_WAIT;
          else         i_q <= i_q + AW'(1);
        end
        S_HIST_WAIT: begin
          k_q <= '0;
          if (!sts_i.pipe_busy) state_q <= S_PREFIX;
        end
        S_PREFIX: begin
          if (k_q == LAST_DIGIT) begin
            i_q     <= last_idx[AW-1:0];
            state_q <= S_PLACE;
          end else begin
            k_q <= k_q + DIG_W'(1);
          end
        end
        S_PLACE: begin
          if (i_q == '0) state_q <= S_PLACE_WAIT;
          else           i_q <= i_q - AW'(1);
        end
        S_PLACE_WAIT: begin
          if (!sts_i.pipe_busy) state_q <= S_DIV;
        end
        S_DIV:      state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!sts_i.pipe_busy) state_q <= S_CHECK;
        end
        S_OUT_RD:   state_q <= S_OUT_LOAD;
        S_OUT_LOAD: state_q <= S_OUT_HOLD;
        S_OUT_HOLD: begin
          if (!sts_i.out_busy) begin
            if (at_last) begin
              i_q     <= '0;
              state_q <= S_LOAD;
            end else begin
              i_q     <= i_q + AW'(1);
              state_q <= S_OUT_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/decimal_lsd_radix_sort.sv -----
// top level of the decimal lsd radix sorter
// depends on drs_pkg, drs_ctrl, drs_datapath and drs_ram
`default_nettype none
// Collects up to MAX_ITEMS values, one per cycle, until a transfer with tlast;
// further values are dropped and flagged on tuser of every result. Each
// decimal digit of the set's maximum then takes a histogram walk and a
// placement walk over the n stored items through one memory read port and
// a divide-by-ten pipeline, a ten-step prefix sum and a maximum divide, up
// to ten digits. Results leave one at a time, each after the sink has taken
// the one before; no input is taken until the last is sent.
module decimal_lsd_radix_sort #(
  parameter int unsigned MAX_ITEMS = drs_pkg::MAX_ITEMS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [31:0]  s_axis_tdata,   // [30:0] value
  input  wire         s_axis_tlast,   // last_in
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] sorted_value
  output logic        m_axis_tlast,   // last_out
  output logic        m_axis_tuser    // dropped
);
  import drs_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic [AW-1:0]    idx;
  logic [CW-1:0]    count;
  logic [VAL_W-1:0] out_value;

  drs_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .count_i    (count),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  drs_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .in_value_i  (s_axis_tdata[VAL_W-1:0]),
    .sts_o       (sts),
    .count_o     (count),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_drop_o  (m_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, out_value};

endmodule
`default_nettype wire

// ----- sim/tb_decimal_lsd_radix_sort.sv -----
// self-checking testbench of the decimal lsd radix sorter
// depends on drs_pkg and decimal_lsd_radix_sort; sets are driven from a queue,
// sorted results are predicted per set and compared transfer by transfer
module tb_decimal_lsd_radix_sort;
  import drs_pkg::*;

  localparam int unsigned CAP = MAX_ITEMS_DEF;
  localparam int unsigned WATCH_LIMIT = 200000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    logic             dropped;
  } out_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tready = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  in_item_t pending_items[$];
  out_item_t sorted_expect[$];
  logic [VAL_W-1:0] set_values[$];
  logic set_overflow = 1'b0;
  int errors = 0;
  int watch_cnt = 0;
  bit calm = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;

  decimal_lsd_radix_sort dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // one stable counting pass per decimal digit of the maximum
  task automatic sort_set_and_expect();
    logic [VAL_W-1:0] vals[$];
    logic [VAL_W-1:0] buckets[10][$];
    logic [VAL_W-1:0] max_v;
    longint unsigned place;
    int n;
    vals = set_values;
    max_v = '0;
    foreach (vals[i]) if (vals[i] > max_v) max_v = vals[i];
    place = 1;
    while (longint'(max_v) / place > 0) begin
      for (int d = 0; d < 10; d++) buckets[d].delete();
      foreach (vals[i]) buckets[(longint'(vals[i]) / place) % 10].push_back(vals[i]);
      vals.delete();
      for (int d = 0; d < 10; d++)
        for (int j = 0; j < buckets[d].size(); j++) vals.push_back(buckets[d][j]);
      place *= 10;
    end
    n = vals.size();
    foreach (vals[i]) sorted_expect.push_back({vals[i], i == n - 1, set_overflow});
    set_values.delete();
    set_overflow = 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    int unsigned digits;
    digits = $urandom_range(0, 10);
    case ($urandom_range(0, 3))
      0: return VAL_W'($urandom);
      1: return VAL_W'($urandom_range(0, 9));
      default: begin
        if (digits == 0) return '0;
        return VAL_W'($urandom_range(0, (digits >= 10) ? 32'h7FFF_FFFF
                                            : int'(10.0 ** digits) - 1));
      end
    endcase
  endfunction

  task automatic queue_set(input int n, input bit random_vals, input logic [VAL_W-1:0] fixed);
    for (int i = 0; i < n; i++)
      pending_items.push_back({random_vals ? rand_value() : fixed, i == n - 1});
  endtask

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      void'(pending_items.pop_front());
    end
    if (!calm && src_gap == 0 && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 5);
    if (src_gap > 0 && !calm && !(s_axis_tvalid && !s_axis_tready)) begin
      src_gap <= src_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (rst_ni && pending_items.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {1'b0, pending_items[0].value};
      s_axis_tlast <= pending_items[0].last;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // input side bookkeeping and monitor
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      if (set_values.size() < CAP) set_values.push_back(s_axis_tdata[VAL_W-1:0]);
      else set_overflow = 1'b1;
      if (s_axis_tlast) sort_set_and_expect();
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (sorted_expect.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        out_item_t e;
        e = sorted_expect.pop_front();
        if (m_axis_tdata[VAL_W-1:0] !== e.value) report_mismatch("value", m_axis_tdata, e.value);
        if (m_axis_tlast !== e.last) report_mismatch("tlast", m_axis_tlast, e.last);
        if (m_axis_tuser !== e.dropped) report_mismatch("tuser", m_axis_tuser, e.dropped);
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt >= WATCH_LIMIT) begin
      $display("[decimal_lsd_radix_sort] ERROR");
      $finish;
    end
    if (!calm && snk_gap == 0 && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 5);
    if (snk_gap > 0 && !calm) begin
      snk_gap <= snk_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  initial begin
    int sent;
    // directed sets
    queue_set(1, 0, '0);
    queue_set(3, 0, '0);
    queue_set(1, 0, 31'h7FFF_FFFF);
    pending_items.push_back({31'h7FFF_FFFF, 1'b0});
    pending_items.push_back({31'd0, 1'b0});
    pending_items.push_back({31'd1000000000, 1'b0});
    pending_items.push_back({31'd9, 1'b0});
    pending_items.push_back({31'h2AAA_AAAA, 1'b0});
    pending_items.push_back({31'h5555_5555, 1'b0});
    pending_items.push_back({31'd10, 1'b1});
    queue_set(4, 0, 31'd777);
    // overflow with a last item dropped too
    queue_set(CAP + 3, 1, '0);
    queue_set(CAP, 1, '0);
    sent = pending_items.size();
    while (sent < 450) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 2, CAP + 4)
                                      : $urandom_range(1, 12);
      queue_set(n, 1, '0);
      sent += n;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() < 60);
    calm = 1'b1;
    wait (pending_items.size() == 0 && !s_axis_tvalid);
    wait (sorted_expect.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && sorted_expect.size() == 0) begin
      $display("[decimal_lsd_radix_sort] OK");
    end else begin
      $display("[decimal_lsd_radix_sort] ERROR");
    end
    $finish;
  end

endmodule

// ----- decimal_lsd_radix_sort.f -----
rtl/drs_pkg.sv
rtl/drs_ram.sv
rtl/drs_datapath.sv
rtl/drs_ctrl.sv
rtl/decimal_lsd_radix_sort.sv
sim/tb_decimal_lsd_radix_sort.sv
